FILE: rtl/kei_pkg.sv
// Shared types, constants and the smoothstep table of the keyframe ease interpolator.
package kei_pkg;

  localparam int TIME_BITS    = 24;
  localparam int VALUE_BITS   = 32;
  localparam int WEIGHT_BITS  = 17;
  localparam int QUOT_BITS    = 16;
  localparam int DIV_STEP     = 2;
  localparam int DIV_STAGES   = QUOT_BITS / DIV_STEP;
  localparam int PROD_BITS    = VALUE_BITS + WEIGHT_BITS + 1;
  localparam int SUM_BITS     = PROD_BITS + 1;

  localparam int CURVE_ENTRIES = 256;
  localparam int CURVE_BITS    = $clog2(CURVE_ENTRIES);
  localparam int IDX_PROD_BITS = CURVE_BITS + WEIGHT_BITS;

  localparam logic [WEIGHT_BITS-1:0]   WEIGHT_ONE = WEIGHT_BITS'(1 << 16);
  localparam logic [VALUE_BITS-1:0]    UNIT_SCALE = VALUE_BITS'(1 << 16);
  localparam logic [IDX_PROD_BITS-1:0] CURVE_MAX  = IDX_PROD_BITS'(CURVE_ENTRIES - 1);
  localparam logic [SUM_BITS-1:0]      ROUND_HALF = SUM_BITS'(1 << 15);

  localparam longint unsigned CURVE_N   = longint'(CURVE_ENTRIES);
  localparam longint unsigned CURVE_DEN = CURVE_N * CURVE_N * CURVE_N;

  typedef enum logic [1:0] {
    EASE_LINEAR,
    EASE_IN_OUT,
    EASE_IN,
    EASE_OUT
  } ease_mode_t;

  // item side data that rides along the divider
  typedef struct packed {
    ease_mode_t                   mode;
    logic                         unit;
    logic                         lo;
    logic                         hi;
    logic signed [VALUE_BITS-1:0] vs;
    logic signed [VALUE_BITS-1:0] ve;
  } kei_side_t;

  // weights and values handed to the blend stages
  typedef struct packed {
    logic                         unit;
    logic [WEIGHT_BITS-1:0]       k1;
    logic [WEIGHT_BITS-1:0]       k2;
    logic signed [VALUE_BITS-1:0] vs;
    logic signed [VALUE_BITS-1:0] ve;
  } kei_blend_t;

  typedef logic [WEIGHT_BITS-1:0] curve_rom_t [CURVE_ENTRIES];

  // x*x*(3-2x) at x = i/N, rounded half up, 16 fraction bits
  function automatic curve_rom_t curve_build();
    curve_rom_t      rom;
    longint unsigned i;
    longint unsigned num;
    for (int k = 0; k < CURVE_ENTRIES; k++) begin
      i      = longint'(k);
      num    = i * i * (3 * CURVE_N - 2 * i) * 64'd65536;
      rom[k] = WEIGHT_BITS'((num + CURVE_DEN / 2) / CURVE_DEN);
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE_ROM = curve_build();

endpackage

FILE: rtl/kei_front.sv
// Input stage: time differences, range flags and unit-scale detect.
module kei_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [kei_pkg::TIME_BITS-1:0]        time_start,
  input  logic [kei_pkg::TIME_BITS-1:0]        time_end,
  input  logic [kei_pkg::TIME_BITS-1:0]        current_time,
  input  logic [1:0]                           ease_mode,
  input  logic                                 is_scale,
  input  logic                                 start_scale_unit,
  input  logic                                 end_scale_unit,
  input  logic signed [kei_pkg::VALUE_BITS-1:0] value_start,
  input  logic signed [kei_pkg::VALUE_BITS-1:0] value_end,
  output logic                                 vld_o,
  output logic [kei_pkg::TIME_BITS-1:0]        diff_o,
  output logic [kei_pkg::TIME_BITS-1:0]        den_o,
  output kei_pkg::kei_side_t                   side_o
);
  import kei_pkg::*;

  logic                  vld_r;
  logic [TIME_BITS-1:0]  diff_r, diff_nxt;
  logic [TIME_BITS-1:0]  den_r, den_nxt;
  kei_side_t             side_r, side_nxt;

  always_comb begin
    diff_nxt      = current_time - time_start;
    den_nxt       = time_end - time_start;
    side_nxt.mode = ease_mode_t'(ease_mode);
    side_nxt.unit = is_scale & start_scale_unit & end_scale_unit;
    side_nxt.lo   = (current_time <= time_start);
    side_nxt.hi   = (current_time >= time_end);
    side_nxt.vs   = value_start;
    side_nxt.ve   = value_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      den_r  <= den_nxt;
      side_r <= side_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign diff_o = diff_r;
  assign den_o  = den_r;
  assign side_o = side_r;

endmodule

FILE: rtl/kei_div.sv
// Pipelined restoring divider for the time fraction, two quotient bits a stage.
module kei_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_i,
  input  logic [kei_pkg::TIME_BITS-1:0]     diff_i,
  input  logic [kei_pkg::TIME_BITS-1:0]     den_i,
  input  kei_pkg::kei_side_t                side_i,
  output logic                              vld_o,
  output logic [kei_pkg::QUOT_BITS-1:0]     quot_o,
  output kei_pkg::kei_side_t                side_o
);
  import kei_pkg::*;

  logic [DIV_STAGES-1:0] vld_r, vld_src;
  logic [TIME_BITS-1:0]  rem_r  [DIV_STAGES];
  logic [TIME_BITS-1:0]  rem_nxt[DIV_STAGES];
  logic [TIME_BITS-1:0]  rem_src[DIV_STAGES];
  logic [TIME_BITS-1:0]  den_r  [DIV_STAGES];
  logic [TIME_BITS-1:0]  den_src[DIV_STAGES];
  logic [QUOT_BITS-1:0]  quot_r  [DIV_STAGES];
  logic [QUOT_BITS-1:0]  quot_nxt[DIV_STAGES];
  logic [QUOT_BITS-1:0]  quot_src[DIV_STAGES];
  kei_side_t             side_r  [DIV_STAGES];
  kei_side_t             side_src[DIV_STAGES];

  always_comb begin
    vld_src[0]  = vld_i;
    rem_src[0]  = diff_i;
    den_src[0]  = den_i;
    quot_src[0] = '0;
    side_src[0] = side_i;
    for (int s = 1; s < DIV_STAGES; s++) begin
      vld_src[s]  = vld_r[s-1];
      rem_src[s]  = rem_r[s-1];
      den_src[s]  = den_r[s-1];
      quot_src[s] = quot_r[s-1];
      side_src[s] = side_r[s-1];
    end
  end

  // remainder stays below the divisor, so the shifted value fits one extra bit
  always_comb begin
    logic [TIME_BITS:0]   shifted;
    logic [TIME_BITS-1:0] rem;
    logic [QUOT_BITS-1:0] quot;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem  = rem_src[s];
      quot = quot_src[s];
      for (int b = 0; b < DIV_STEP; b++) begin
        shifted = {rem, 1'b0};
        if (shifted >= {1'b0, den_src[s]}) begin
          rem  = TIME_BITS'(shifted - {1'b0, den_src[s]});
          quot = {quot[QUOT_BITS-2:0], 1'b1};
        end else begin
          rem  = shifted[TIME_BITS-1:0];
          quot = {quot[QUOT_BITS-2:0], 1'b0};
        end
      end
      rem_nxt[s]  = rem;
      quot_nxt[s] = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_src;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s]  <= rem_nxt[s];
        den_r[s]  <= den_src[s];
        quot_r[s] <= quot_nxt[s];
        side_r[s] <= side_src[s];
      end
    end
  end

  assign vld_o  = vld_r[DIV_STAGES-1];
  assign quot_o = quot_r[DIV_STAGES-1];
  assign side_o = side_r[DIV_STAGES-1];

endmodule

FILE: rtl/kei_ease.sv
// Weight clamp and easing: curve index, then table read and weight select.
module kei_ease (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic [kei_pkg::QUOT_BITS-1:0] quot_i,
  input  kei_pkg::kei_side_t            side_i,
  output logic                          vld_o,
  output kei_pkg::kei_blend_t           blend_o
);
  import kei_pkg::*;

  logic [WEIGHT_BITS-1:0]   k1_c, k2_c, w_c;
  logic [IDX_PROD_BITS-1:0] idx_prod;
  logic [CURVE_BITS-1:0]    idx_nxt;

  logic                     vld1_r;
  logic [CURVE_BITS-1:0]    idx_r;
  logic [WEIGHT_BITS-1:0]   k1_r, k2_r;
  ease_mode_t               mode_r;
  logic                     unit_r;
  logic signed [VALUE_BITS-1:0] vs_r, ve_r;

  logic [WEIGHT_BITS-1:0]   rom_val;
  logic [WEIGHT_BITS:0]     dbl;
  logic [WEIGHT_BITS-1:0]   half_w;
  kei_blend_t               blend_nxt;
  logic                     vld2_r;
  kei_blend_t               blend_r;

  // stage one: clamped linear weights and the table index
  always_comb begin
    if (side_i.lo) begin
      k2_c = '0;
    end else if (side_i.hi) begin
      k2_c = WEIGHT_ONE;
    end else begin
      k2_c = {1'b0, quot_i};
    end
    k1_c     = WEIGHT_ONE - k2_c;
    w_c      = (side_i.mode == EASE_OUT) ? k2_c : k1_c;
    idx_prod = CURVE_MAX * IDX_PROD_BITS'(w_c);
    // ease in and out look up at half the weight
    if (side_i.mode == EASE_IN_OUT) begin
      idx_nxt = idx_prod[CURVE_BITS+15:16];
    end else begin
      idx_nxt = idx_prod[CURVE_BITS+16:17];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r  <= idx_nxt;
      k1_r   <= k1_c;
      k2_r   <= k2_c;
      mode_r <= side_i.mode;
      unit_r <= side_i.unit;
      vs_r   <= side_i.vs;
      ve_r   <= side_i.ve;
    end
  end

  // stage two: table read and final weights
  always_comb begin
    rom_val = CURVE_ROM[idx_r];
    dbl     = {rom_val, 1'b0};
    half_w  = (dbl > {1'b0, WEIGHT_ONE}) ? WEIGHT_ONE : dbl[WEIGHT_BITS-1:0];
    blend_nxt.unit = unit_r;
    blend_nxt.vs   = vs_r;
    blend_nxt.ve   = ve_r;
    unique case (mode_r)
      EASE_LINEAR: begin
        blend_nxt.k1 = k1_r;
        blend_nxt.k2 = k2_r;
      end
      EASE_IN_OUT: begin
        blend_nxt.k1 = rom_val;
        blend_nxt.k2 = WEIGHT_ONE - rom_val;
      end
      EASE_IN: begin
        blend_nxt.k1 = half_w;
        blend_nxt.k2 = WEIGHT_ONE - half_w;
      end
      EASE_OUT: begin
        blend_nxt.k2 = half_w;
        blend_nxt.k1 = WEIGHT_ONE - half_w;
      end
      default: begin
        blend_nxt.k1 = k1_r;
        blend_nxt.k2 = k2_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blend_r <= blend_nxt;
    end
  end

  assign vld_o   = vld2_r;
  assign blend_o = blend_r;

endmodule

FILE: rtl/kei_blend.sv
// Blend stages: two weight products, rounded sum, output register.
module kei_blend (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  vld_i,
  input  kei_pkg::kei_blend_t                   blend_i,
  output logic                                  vld_o,
  output logic [kei_pkg::VALUE_BITS-1:0]        value_o
);
  import kei_pkg::*;

  logic signed [PROD_BITS-1:0] p1_nxt, p2_nxt, p1_r, p2_r;
  logic                        unit_r, vld1_r;
  logic signed [SUM_BITS-1:0]  sum;
  logic [VALUE_BITS-1:0]       value_nxt, value_r;
  logic                        vld2_r;

  always_comb begin
    p1_nxt = PROD_BITS'(blend_i.vs) * PROD_BITS'($signed({1'b0, blend_i.k1}));
    p2_nxt = PROD_BITS'(blend_i.ve) * PROD_BITS'($signed({1'b0, blend_i.k2}));
  end

  // k1 + k2 is one, so the rounded sum always fits the value width
  always_comb begin
    sum       = SUM_BITS'(p1_r) + SUM_BITS'(p2_r) + $signed(ROUND_HALF);
    value_nxt = unit_r ? UNIT_SCALE : sum[VALUE_BITS+15:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      unit_r  <= blend_i.unit;
      value_r <= value_nxt;
    end
  end

  assign vld_o   = vld2_r;
  assign value_o = value_r;

endmodule

FILE: rtl/keyframe_ease_interpolator.sv
// Top level of the keyframe ease interpolator: pipeline wiring and checks.
//
//  channel | dir | ports                        | content
//  in_     | in  | in_tvalid/tready/tdata/tuser | keyframe times, values, mode, scale flags
//  out_    | out | out_tvalid/tready/tdata      | blended value
//
// One item a cycle while out_tready allows it; the pipeline has one input stage, eight
// divider stages (two quotient bits each), two easing stages and two blend stages.
// Reset (rst_n low, synchronous) empties the pipeline; no state is kept between items.
// A stall on the output freezes every stage together, so in_tready follows
// out_tready whenever a result is waiting.
module keyframe_ease_interpolator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [23:0] time_start, [47:24] time_end, [71:48] current_time,
  // [103:72] value_start, [135:104] value_end
  input  logic [135:0] in_tdata,
  // [1:0] ease_mode, [2] is_scale, [3] start_scale_unit, [4] end_scale_unit
  input  logic [4:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] value_out
  output logic [31:0]  out_tdata
);
  import kei_pkg::*;

  logic                  en;
  logic                  fr_vld, dv_vld, ea_vld;
  logic [TIME_BITS-1:0]  fr_diff, fr_den;
  kei_side_t             fr_side, dv_side;
  logic [QUOT_BITS-1:0]  dv_quot;
  kei_blend_t            ea_blend;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  kei_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .in_valid         (in_tvalid),
    .time_start       (in_tdata[23:0]),
    .time_end         (in_tdata[47:24]),
    .current_time     (in_tdata[71:48]),
    .ease_mode        (in_tuser[1:0]),
    .is_scale         (in_tuser[2]),
    .start_scale_unit (in_tuser[3]),
    .end_scale_unit   (in_tuser[4]),
    .value_start      ($signed(in_tdata[103:72])),
    .value_end        ($signed(in_tdata[135:104])),
    .vld_o            (fr_vld),
    .diff_o           (fr_diff),
    .den_o            (fr_den),
    .side_o           (fr_side)
  );

  kei_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (fr_vld),
    .diff_i (fr_diff),
    .den_i  (fr_den),
    .side_i (fr_side),
    .vld_o  (dv_vld),
    .quot_o (dv_quot),
    .side_o (dv_side)
  );

  kei_ease u_ease (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (dv_vld),
    .quot_i  (dv_quot),
    .side_i  (dv_side),
    .vld_o   (ea_vld),
    .blend_o (ea_blend)
  );

  kei_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (ea_vld),
    .blend_i (ea_blend),
    .vld_o   (out_tvalid),
    .value_o (out_tdata)
  );

`ifndef SYNTHESIS
  // a time strictly inside the keyframe pair must give a proper fraction
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    fr_vld && !fr_side.lo && !fr_side.hi |-> (fr_diff < fr_den))
    else $error("time difference not below keyframe span");

  // eased weights always sum to one
  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ea_vld |-> (({1'b0, ea_blend.k1} + {1'b0, ea_blend.k2}) == {1'b0, WEIGHT_ONE}))
    else $error("blend weights do not sum to one");

  // a unit-scale item leaving the easing stages yields exactly one
  a_unit_scale: assert property (@(posedge clk) disable iff (!rst_n)
    en && ea_vld && ea_blend.unit ##1 en |=> out_tvalid && (out_tdata == UNIT_SCALE))
    else $error("unit scale channel not one");
`endif

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the keyframe ease interpolator: directed and random keyframe items against a blend predictor.
`timescale 1ns / 100ps

module tb_top;
  import kei_pkg::*;

  localparam int RAND_ITEMS  = 725;
  localparam int QUIET_ITEMS = 150;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_BURST  = 40;
  localparam int DRAIN_AT    = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [23:0]        t_start;
    logic [23:0]        t_end;
    logic [23:0]        t_now;
    ease_mode_t         mode;
    logic               is_scale;
    logic               start_unit;
    logic               end_unit;
    logic signed [31:0] v_start;
    logic signed [31:0] v_end;
  } key_item_t;

  // holds the blended values still owed by the block, oldest first
  class blend_scoreboard;
    logic [31:0] expected_values[$];
    int          n_checked;
    int          n_errors;
    int          n_reported;

    // smoothstep x*x*(3-2x) at x = idx/N, rounded half up, 16 fraction bits
    function automatic logic [16:0] curve_point(longint unsigned idx);
      longint unsigned n;
      longint unsigned i;
      longint unsigned num;
      n = longint'(CURVE_ENTRIES);
      i = (idx > n - 1) ? n - 1 : idx;
      num = i * i * (3 * n - 2 * i) * 64'd65536;
      return 17'((num + (n * n * n) / 2) / (n * n * n));
    endfunction

    // half-range lookup used by ease in / ease out, doubled and clamped to one
    function automatic logic [16:0] half_curve(logic [16:0] w);
      longint unsigned idx;
      longint unsigned v;
      idx = (longint'(CURVE_ENTRIES - 1) * longint'(w)) >> 17;
      v = 2 * longint'(curve_point(idx));
      return (v > 65536) ? 17'h10000 : 17'(v);
    endfunction

    function automatic logic [31:0] predict_blend(key_item_t it);
      logic [16:0] k1;
      logic [16:0] k2;
      logic [39:0] num;
      longint      sum;
      if (it.is_scale && it.start_unit && it.end_unit)
        return 32'h0001_0000;
      if (it.t_now <= it.t_start) begin
        k2 = '0;
      end else if (it.t_now >= it.t_end) begin
        k2 = 17'h10000;
      end else begin
        num = {16'(0), 24'(it.t_now - it.t_start)} << 16;
        k2 = 17'(num / 40'(it.t_end - it.t_start));
      end
      k1 = 17'h10000 - k2;
      case (it.mode)
        EASE_IN_OUT: begin
          k1 = curve_point((longint'(CURVE_ENTRIES - 1) * longint'(k1)) >> 16);
          k2 = 17'h10000 - k1;
        end
        EASE_IN: begin
          k1 = half_curve(k1);
          k2 = 17'h10000 - k1;
        end
        EASE_OUT: begin
          k2 = half_curve(k2);
          k1 = 17'h10000 - k2;
        end
        default: ;
      endcase
      sum = longint'(it.v_start) * longint'(k1) + longint'(it.v_end) * longint'(k2);
      sum = (sum + 32768) >>> 16;
      return sum[31:0];
    endfunction

    function void note_item(key_item_t it);
      expected_values.push_back(predict_blend(it));
    endfunction

    function void check_value(logic [31:0] actual);
      logic [31:0] want;
      if (expected_values.size() == 0) begin
        n_errors++;
        if (n_reported < MAX_REPORTS) begin
          n_reported++;
          $display("[%0t] unexpected result %h with nothing outstanding", $realtime, actual);
        end
        return;
      end
      want = expected_values.pop_front();
      n_checked++;
      if (actual !== want) begin
        n_errors++;
        if (n_reported < MAX_REPORTS) begin
          n_reported++;
          $display("[%0t] value_out mismatch on result %0d: expected %h, got %h",
                   $realtime, n_checked, want, actual);
        end
      end
    endfunction

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic [4:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;

  blend_scoreboard sb;
  bit              hold_req;
  int              rx_stall_pct;
  int              n_sent;
  int              mode_count[4];
  int              n_unit;
  int              n_clamped;
  int              n_reversed;

  keyframe_ease_interpolator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_tready <= 1'b1;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_value(out_tdata);
  end

  function automatic key_item_t mk(logic [23:0] ts, logic [23:0] te, logic [23:0] tc,
                                   ease_mode_t md, logic [2:0] flags,
                                   logic [31:0] vs, logic [31:0] ve);
    key_item_t it;
    it.t_start    = ts;
    it.t_end      = te;
    it.t_now      = tc;
    it.mode       = md;
    it.is_scale   = flags[2];
    it.start_unit = flags[1];
    it.end_unit   = flags[0];
    it.v_start    = vs;
    it.v_end      = ve;
    return it;
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1: return 32'($signed($urandom_range(0, 200_000)) - 100_000);
      default: return $urandom;
    endcase
  endfunction

  function automatic key_item_t random_item();
    key_item_t   it;
    logic [23:0] span;
    case ($urandom_range(0, 9))
      0: begin // keyframes out of order or equal
        it.t_start = 24'($urandom);
        it.t_end   = 24'($urandom_range(0, it.t_start));
      end
      1, 2, 3, 4, 5: begin
        span       = 24'($urandom_range(1, 4096));
        it.t_start = 24'($urandom_range(0, 24'hFF_FFFF - span));
        it.t_end   = it.t_start + span;
      end
      6, 7, 8: begin
        span       = 24'($urandom_range(1, 1 << 20));
        it.t_start = 24'($urandom_range(0, 24'hFF_FFFF - span));
        it.t_end   = it.t_start + span;
      end
      default: begin
        it.t_start = 24'($urandom);
        it.t_end   = 24'($urandom);
      end
    endcase
    case ($urandom_range(0, 9))
      0: it.t_now = it.t_start;
      1: it.t_now = it.t_end;
      2: it.t_now = 24'($urandom_range(0, it.t_start));
      3: it.t_now = 24'($urandom_range(it.t_end, 24'hFF_FFFF));
      4: it.t_now = 24'($urandom);
      default: it.t_now = 24'($urandom_range(it.t_start, it.t_end));
    endcase
    it.mode       = ease_mode_t'($urandom_range(0, 3));
    it.is_scale   = 1'($urandom);
    it.start_unit = 1'($urandom);
    it.end_unit   = 1'($urandom);
    it.v_start    = random_value();
    it.v_end      = random_value();
    return it;
  endfunction

  // offer one item and hold it until the block takes it
  task automatic send_item(key_item_t it);
    in_tvalid <= 1'b1;
    in_tdata  <= {it.v_end, it.v_start, it.t_now, it.t_end, it.t_start};
    in_tuser  <= {it.end_unit, it.start_unit, it.is_scale, it.mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(it);
    n_sent++;
    mode_count[it.mode]++;
    if (it.is_scale && it.start_unit && it.end_unit)
      n_unit++;
    else if (it.t_now <= it.t_start || it.t_now >= it.t_end)
      n_clamped++;
    if (it.t_end <= it.t_start)
      n_reversed++;
  endtask

  task automatic idle_gap(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    key_item_t directed[$];
    int        tx_gap_pct;
    bit        quiet;

    sb           = new;
    hold_req     = 1'b0;
    rx_stall_pct = 0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    rst_n        = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fraction clamps and keyframe ordering
    directed.push_back(mk(24'd0, 24'd256, 24'd128, EASE_LINEAR, 3'b000, 32'h10000, 32'h30000));
    directed.push_back(mk(24'd500, 24'd900, 24'd500, EASE_LINEAR, 3'b000, 32'h7000, 32'h9000));
    directed.push_back(mk(24'd500, 24'd900, 24'd10, EASE_LINEAR, 3'b100, 32'h7000, 32'h9000));
    directed.push_back(mk(24'd500, 24'd900, 24'd900, EASE_LINEAR, 3'b010, 32'h7000, 32'h9000));
    directed.push_back(mk(24'd500, 24'd900, 24'hFF_FFFF, EASE_LINEAR, 3'b001, 32'h7000, 32'h9000));
    directed.push_back(mk(24'd900, 24'd500, 24'd700, EASE_IN_OUT, 3'b000, 32'h1234, 32'h5678));
    directed.push_back(mk(24'd900, 24'd900, 24'd900, EASE_IN, 3'b000, 32'h1234, 32'h5678));
    directed.push_back(mk(24'd900, 24'd900, 24'd901, EASE_OUT, 3'b000, 32'h1234, 32'h5678));
    // each easing mode at a quarter and at one end
    directed.push_back(mk(24'd0, 24'd400, 24'd100, EASE_IN_OUT, 3'b000, 32'hFFFF0000, 32'h50000));
    directed.push_back(mk(24'd0, 24'd400, 24'd100, EASE_IN, 3'b000, 32'hFFFF0000, 32'h50000));
    directed.push_back(mk(24'd0, 24'd400, 24'd100, EASE_OUT, 3'b000, 32'hFFFF0000, 32'h50000));
    directed.push_back(mk(24'd0, 24'd400, 24'd0, EASE_IN, 3'b000, 32'h0, 32'h7FFF_FFFF));
    directed.push_back(mk(24'd0, 24'd400, 24'd400, EASE_OUT, 3'b000, 32'h0, 32'h7FFF_FFFF));
    directed.push_back(mk(24'd0, 24'd400, 24'd0, EASE_IN_OUT, 3'b000, 32'h8000_0000, 32'h0));
    // widest times
    directed.push_back(mk(24'd0, 24'hFF_FFFF, 24'h7F_FFFF, EASE_IN_OUT, 3'b000,
                          32'h8000_0000, 32'h7FFF_FFFF));
    directed.push_back(mk(24'hFF_FFFE, 24'hFF_FFFF, 24'hFF_FFFF, EASE_LINEAR, 3'b000,
                          32'h7FFF_FFFF, 32'h8000_0000));
    directed.push_back(mk(24'd0, 24'hFF_FFFF, 24'd1, EASE_LINEAR, 3'b000,
                          32'h8000_0000, 32'h8000_0000));
    // rounding ties at exactly half
    directed.push_back(mk(24'd0, 24'd2, 24'd1, EASE_LINEAR, 3'b000, 32'h1, 32'h0));
    directed.push_back(mk(24'd0, 24'd2, 24'd1, EASE_LINEAR, 3'b000, 32'hFFFF_FFFF, 32'h0));
    // unit scale and its near misses
    directed.push_back(mk(24'd0, 24'd400, 24'd100, EASE_IN, 3'b111, 32'h8000_0000, 32'h7FFF_FFFF));
    directed.push_back(mk(24'd900, 24'd5, 24'd0, EASE_OUT, 3'b111, 32'h0, 32'h0));
    directed.push_back(mk(24'd0, 24'd400, 24'd100, EASE_LINEAR, 3'b110, 32'h20000, 32'h10000));
    directed.push_back(mk(24'd0, 24'd400, 24'd100, EASE_LINEAR, 3'b101, 32'h20000, 32'h10000));
    directed.push_back(mk(24'd0, 24'd400, 24'd100, EASE_LINEAR, 3'b011, 32'h20000, 32'h10000));

    foreach (directed[i])
      send_item(directed[i]);

    tx_gap_pct = 0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      quiet = (i >= RAND_ITEMS - QUIET_ITEMS);
      if (i % 60 == 0) begin
        tx_gap_pct   = $urandom_range(0, 2) == 0 ? 0 : 25;
        rx_stall_pct = $urandom_range(0, 2) == 0 ? 0 : 10;
      end
      if (quiet) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
      if (i == HOLD_AT)
        hold_req = 1'b1;
      if (i == DRAIN_AT) begin
        in_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      send_item(random_item());
      // back-to-back while the receiver is held so the pipeline backs up
      if (!(i >= HOLD_AT && i < HOLD_AT + HOLD_BURST) &&
          tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
        idle_gap($urandom_range(1, 12));
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Run: %0d items (linear %0d, in-out %0d, in %0d, out %0d), %0d results checked",
             n_sent, mode_count[EASE_LINEAR], mode_count[EASE_IN_OUT],
             mode_count[EASE_IN], mode_count[EASE_OUT], sb.n_checked);
    $display("     %0d unit-scale, %0d clamped fractions, %0d reversed keyframes, %0d errors",
             n_unit, n_clamped, n_reversed, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
rtl/kei_pkg.sv
rtl/kei_front.sv
rtl/kei_div.sv
rtl/kei_ease.sv
rtl/kei_blend.sv
rtl/keyframe_ease_interpolator.sv
bench/tb_top.sv
